### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/gtfa_pkg.sv
// ---------------------------------------------------------------------------
// gtfa_pkg: shared types and constants
// Types, op codes and sizes of the gradient tensor face accumulator.
// ---------------------------------------------------------------------------
package gtfa_pkg;

    localparam int MAX_CELLS = 4096;
    localparam int CELL_W    = 12;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int ACC_W     = 48;
    localparam int NCOMP     = 9;

    typedef enum logic [1:0] {
        OP_INTERNAL = 2'd0,
        OP_BOUNDARY = 2'd1,
        OP_FINALIZE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // one classified beat passed from front to back
    typedef struct packed {
        op_t                op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [CELL_W-1:0]  owner;
        logic [CELL_W-1:0]  neigh;
        logic               owner_ok;
        logic               neigh_ok;
        logic               scale_neg;
        logic [31:0]        smag;
        logic [30:0]        vol;
    } item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROD,
        ST_RD,
        ST_WAIT,
        ST_WR,
        ST_FIN_MUL,
        ST_FIN_ACC,
        ST_OUT
    } state_t;

    // saturate a 50-bit signed value to 48 bits
    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] hi;
        logic signed [ACC_W+1:0] lo;
        hi = {3'b000, {(ACC_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) return hi[ACC_W-1:0];
        if (v < lo) return lo[ACC_W-1:0];
        return v[ACC_W-1:0];
    endfunction

endpackage

### src/gtfa_front.sv
// ---------------------------------------------------------------------------
// gtfa_front: input classifier and queue
// Accepts beats, checks cell ranges, takes magnitudes, queues two items.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gtfa_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              in_op,
    input  logic [31:0]             in_ax,
    input  logic [31:0]             in_ay,
    input  logic [31:0]             in_az,
    input  logic [31:0]             in_vx,
    input  logic [31:0]             in_vy,
    input  logic [31:0]             in_vz,
    input  logic [11:0]             in_owner,
    input  logic [11:0]             in_neigh,
    input  logic [31:0]             in_scale,
    input  logic [30:0]             in_vol,
    output logic                    q_valid,
    input  logic                    q_pop,
    output gtfa_pkg::item_t         q_item
);

    gtfa_pkg::item_t q_mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    gtfa_pkg::item_t it;
    logic            push;

    // classify
    always_comb
    begin
        it.op       = gtfa_pkg::op_t'(in_op);
        it.ax       = in_ax;
        it.ay       = in_ay;
        it.az       = in_az;
        it.vx       = in_vx;
        it.vy       = in_vy;
        it.vz       = in_vz;
        it.owner    = in_owner;
        it.neigh    = in_neigh;
        it.owner_ok = 32'(in_owner) < gtfa_pkg::MAX_CELLS;
        it.neigh_ok = 32'(in_neigh) < gtfa_pkg::MAX_CELLS;
        it.scale_neg = in_scale[31];
        it.smag     = in_scale[31] ? (~in_scale + 32'd1) : in_scale;
        it.vol      = (in_vol == 31'd0) ? 31'd1 : in_vol;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wp_reg] <= it;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && cnt_reg == 2'd2, "queue overflow")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, q_pop && cnt_reg == 2'd0, "queue underflow")
    `ASSERT_IMPL(a_cnt_step, clk, rst_n, (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1,
        "queue count did not grow")

endmodule

### src/gtfa_back.sv
// ---------------------------------------------------------------------------
// gtfa_back: tensor store and arithmetic sequencer
// Forms products, read-modify-writes the store, finalizes and clears cells.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gtfa_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  gtfa_pkg::item_t                q_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [11:0]                    out_cell,
    output logic [gtfa_pkg::NCOMP*gtfa_pkg::ACC_W-1:0] out_grad
);

    localparam int AW = gtfa_pkg::ADDR_W;
    localparam int W  = gtfa_pkg::ACC_W;
    localparam int MW = AW + 4;

    gtfa_pkg::state_t state_reg, state_next;
    gtfa_pkg::item_t  it_reg;

    logic [W-1:0]    mem [gtfa_pkg::MAX_CELLS*gtfa_pkg::NCOMP];
    logic [W-1:0]    rd_reg;
    logic [MW-1:0]   clr_reg;
    logic [3:0]      k_reg;
    logic            side_reg;
    logic signed [W-1:0] prod_reg [gtfa_pkg::NCOMP];
    logic [W-1:0]    grad_reg [gtfa_pkg::NCOMP];
    logic [31:0]     rem_reg;
    logic [63:0]     ratio_reg;
    logic [6:0]      dcnt_reg;
    logic [W-1:0]    mag_reg;
    logic            neg_reg;
    logic [W-1:0]    pp0_reg;
    logic [79:0]     pp1_reg;

    logic [AW-1:0]   cell_sel;
    logic [MW-1:0]   addr;
    logic            wr_en;
    logic [W-1:0]    wr_data;
    logic            last_k;

    assign cell_sel = side_reg ? it_reg.neigh[AW-1:0] : it_reg.owner[AW-1:0];
    assign addr     = MW'(cell_sel) * MW'(gtfa_pkg::NCOMP) + MW'(k_reg);
    assign last_k   = (k_reg == 4'(gtfa_pkg::NCOMP - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gtfa_pkg::ST_CLEAR:
                if (clr_reg == MW'(gtfa_pkg::MAX_CELLS*gtfa_pkg::NCOMP - 1))
                    state_next = gtfa_pkg::ST_IDLE;
            gtfa_pkg::ST_IDLE:
                if (q_valid)
                begin
                    if (q_item.op == gtfa_pkg::OP_FINALIZE) state_next = gtfa_pkg::ST_DIV;
                    else if (q_item.op == gtfa_pkg::OP_NONE || !q_item.owner_ok &&
                             !(q_item.op == gtfa_pkg::OP_INTERNAL && q_item.neigh_ok))
                        state_next = gtfa_pkg::ST_IDLE;
                    else state_next = gtfa_pkg::ST_PROD;
                end
            gtfa_pkg::ST_DIV:
                if (dcnt_reg == 7'd63)
                    state_next = it_reg.owner_ok ? gtfa_pkg::ST_RD : gtfa_pkg::ST_OUT;
            gtfa_pkg::ST_PROD:  state_next = gtfa_pkg::ST_RD;
            gtfa_pkg::ST_RD:    state_next = gtfa_pkg::ST_WAIT;
            gtfa_pkg::ST_WAIT:
                state_next = (it_reg.op == gtfa_pkg::OP_FINALIZE) ? gtfa_pkg::ST_FIN_MUL
                                                                   : gtfa_pkg::ST_WR;
            gtfa_pkg::ST_WR:
                if (!last_k) state_next = gtfa_pkg::ST_RD;
                else if (!side_reg && it_reg.op == gtfa_pkg::OP_INTERNAL && it_reg.neigh_ok)
                    state_next = gtfa_pkg::ST_RD;
                else state_next = gtfa_pkg::ST_IDLE;
            gtfa_pkg::ST_FIN_MUL: state_next = gtfa_pkg::ST_FIN_ACC;
            gtfa_pkg::ST_FIN_ACC:
                state_next = last_k ? gtfa_pkg::ST_OUT : gtfa_pkg::ST_RD;
            gtfa_pkg::ST_OUT:
                if (out_ready) state_next = gtfa_pkg::ST_IDLE;
            default: state_next = gtfa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = (state_reg == gtfa_pkg::ST_IDLE) && q_valid;
        out_valid = (state_reg == gtfa_pkg::ST_OUT);
        wr_en     = 1'b0;
        wr_data   = '0;
        case (state_reg)
            gtfa_pkg::ST_WR:
            begin
                wr_en   = side_reg ? it_reg.neigh_ok : it_reg.owner_ok;
                wr_data = side_reg
                    ? gtfa_pkg::sat48({{2{rd_reg[W-1]}}, rd_reg} -
                                      {{2{prod_reg[k_reg][W-1]}}, prod_reg[k_reg]})
                    : gtfa_pkg::sat48({{2{rd_reg[W-1]}}, rd_reg} +
                                      {{2{prod_reg[k_reg][W-1]}}, prod_reg[k_reg]});
            end
            gtfa_pkg::ST_FIN_ACC: wr_en = 1'b1;
            default: wr_en = 1'b0;
        endcase
    end

    // tensor store
    always_ff @(posedge clk)
    begin
        if (state_reg == gtfa_pkg::ST_CLEAR) mem[clr_reg] <= '0;
        else if (wr_en) mem[addr] <= wr_data;
        rd_reg <= mem[addr];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        logic [W:0]   sum;
        logic [W-1:0] q;
        logic [32:0]  tr;
        logic [32:0]  df;
        tr = {rem_reg, ratio_reg[63]};
        df = tr - {2'b00, it_reg.vol};
        if (state_reg == gtfa_pkg::ST_IDLE && q_valid)
        begin
            it_reg    <= q_item;
            rem_reg   <= '0;
            ratio_reg <= {q_item.smag, 32'd0};
        end
        // restoring division, one quotient bit per cycle; the dividend shifts
        // out of ratio_reg as the quotient shifts in
        if (state_reg == gtfa_pkg::ST_DIV)
        begin
            if (tr >= {2'b00, it_reg.vol})
            begin
                rem_reg   <= df[31:0];
                ratio_reg <= {ratio_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg   <= tr[31:0];
                ratio_reg <= {ratio_reg[62:0], 1'b0};
            end
        end
        if (state_reg == gtfa_pkg::ST_PROD)
        begin
            prod_reg[0] <= W'((64'(it_reg.ax) * 64'(it_reg.vx)) >>> 16);
            prod_reg[1] <= W'((64'(it_reg.ax) * 64'(it_reg.vy)) >>> 16);
            prod_reg[2] <= W'((64'(it_reg.ax) * 64'(it_reg.vz)) >>> 16);
            prod_reg[3] <= W'((64'(it_reg.ay) * 64'(it_reg.vx)) >>> 16);
            prod_reg[4] <= W'((64'(it_reg.ay) * 64'(it_reg.vy)) >>> 16);
            prod_reg[5] <= W'((64'(it_reg.ay) * 64'(it_reg.vz)) >>> 16);
            prod_reg[6] <= W'((64'(it_reg.az) * 64'(it_reg.vx)) >>> 16);
            prod_reg[7] <= W'((64'(it_reg.az) * 64'(it_reg.vy)) >>> 16);
            prod_reg[8] <= W'((64'(it_reg.az) * 64'(it_reg.vz)) >>> 16);
        end
        // finalize: magnitude times ratio in two 48x32 halves
        if (state_reg == gtfa_pkg::ST_FIN_MUL)
        begin
            pp0_reg <= W'((80'(mag_reg) * 80'(ratio_reg[31:0])) >> 32);
            pp1_reg <= 80'(mag_reg) * 80'(ratio_reg[63:32]);
        end
        if (state_reg == gtfa_pkg::ST_WAIT)
        begin
            mag_reg <= rd_reg[W-1] ? (~rd_reg + W'(1)) : rd_reg;
            neg_reg <= rd_reg[W-1] ^ it_reg.scale_neg;
        end
        if (state_reg == gtfa_pkg::ST_FIN_ACC)
        begin
            // pp1 holds mag*ratio_hi; full q = (mag*ratio_hi) + pp0
            sum = '0;
            q   = '0;
            if (pp1_reg[79:W] != '0)
                q = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            else
            begin
                sum = (W+1)'(pp1_reg[W-1:0]) + (W+1)'(pp0_reg);
                if (!neg_reg)
                    q = sum[W:W-1] != 2'b00 ? {1'b0, {(W-1){1'b1}}} : sum[W-1:0];
                else
                    q = (sum > (W+1)'({1'b1, {(W-1){1'b0}}})) ? {1'b1, {(W-1){1'b0}}}
                                                                : (~sum[W-1:0] + W'(1));
            end
            grad_reg[k_reg] <= q;
        end
        if (state_reg == gtfa_pkg::ST_DIV && dcnt_reg == 7'd0)
        begin
            for (int i = 0; i < gtfa_pkg::NCOMP; i++) grad_reg[i] <= '0;
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtfa_pkg::ST_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            side_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gtfa_pkg::ST_CLEAR) clr_reg <= clr_reg + MW'(1);
            if (state_reg == gtfa_pkg::ST_IDLE)
            begin
                k_reg    <= '0;
                dcnt_reg <= '0;
                side_reg <= !(q_item.owner_ok);
            end
            if (state_reg == gtfa_pkg::ST_DIV) dcnt_reg <= dcnt_reg + 7'd1;
            if (state_reg == gtfa_pkg::ST_WR || state_reg == gtfa_pkg::ST_FIN_ACC)
            begin
                if (last_k)
                begin
                    k_reg    <= '0;
                    side_reg <= 1'b1;
                end
                else k_reg <= k_reg + 4'd1;
            end
        end
    end

    assign out_cell = it_reg.owner;
    always_comb
    begin
        for (int i = 0; i < gtfa_pkg::NCOMP; i++)
            out_grad[i*W +: W] = grad_reg[i];
    end

    `ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid,
        "result dropped while stalled")
    `ASSERT_NEVER(a_pop_busy, clk, rst_n, q_pop && state_reg != gtfa_pkg::ST_IDLE,
        "pop while busy")
    `ASSERT_NEVER(a_wr_clear, clk, rst_n, wr_en && state_reg == gtfa_pkg::ST_CLEAR,
        "write during clear")

endmodule

### src/gradient_tensor_face_accumulator.sv
// ---------------------------------------------------------------------------
// gradient_tensor_face_accumulator: top level
// Per-cell 3x3 gradient tensor accumulator over a shared store.
// ---------------------------------------------------------------------------
// Face beat: form products, then read, wait, write per component per cell touched.
// Finalize beat: restoring divider, then read, wait, multiply and accumulate per
// component, then output.
// A two-entry queue decouples input acceptance from the sequencer.
// Reset: asynchronous; a clearing pass over all MAX_CELLS*9 = 36864 store words
// follows, during which beats queue but are not processed.
module gradient_tensor_face_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, area_x, area_y, area_z, face_val_x, face_val_y, face_val_z,
    // owner_cell, neighbour_cell, scale_factor, cell_volume, zero pad
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_index, grad_xx .. grad_zz row-major, zero pad
    output logic [447:0] m_tdata
);

    logic            q_valid, q_pop;
    gtfa_pkg::item_t q_item;
    logic [11:0]     out_idx;
    logic [431:0]    grad;

    gtfa_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[1:0]),
        .in_ax(s_tdata[33:2]), .in_ay(s_tdata[65:34]), .in_az(s_tdata[97:66]),
        .in_vx(s_tdata[129:98]), .in_vy(s_tdata[161:130]), .in_vz(s_tdata[193:162]),
        .in_owner(s_tdata[205:194]), .in_neigh(s_tdata[217:206]),
        .in_scale(s_tdata[249:218]), .in_vol(s_tdata[280:250]),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    gtfa_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_cell(out_idx), .out_grad(grad)
    );

    assign m_tdata = {4'd0, grad, out_idx};

endmodule
